// File: hw/rtl/bpsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpsd_pkg;

    // Image size limits and coordinate widths.
    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PALETTE_DEPTH = 256;
    localparam int DIM_W         = 13;
    localparam int COORD_W       = 12;
    localparam int PAL_AW        = 8;
    localparam int PCNT_W        = 10;

    // Pixel format codes.
    localparam logic [2:0] FMT_1BPP  = 3'd0;
    localparam logic [2:0] FMT_4BPP  = 3'd1;
    localparam logic [2:0] FMT_8BPP  = 3'd2;
    localparam logic [2:0] FMT_24BPP = 3'd3;
    localparam logic [2:0] FMT_32BPP = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FORMAT = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // Palette byte lanes inside one four-byte entry.
    localparam logic [1:0] LANE_BLUE  = 2'd0;
    localparam logic [1:0] LANE_GREEN = 2'd1;
    localparam logic [1:0] LANE_RED   = 2'd2;

    // Palette write request, one byte lane at a time.
    typedef struct packed {
        logic [2:0]        lane_we;
        logic [PAL_AW-1:0] addr;
        logic [7:0]        data;
    } bpsd_pal_wr_t;

    // A run of one to eight pixels produced by one data byte.
    typedef struct packed {
        logic               indexed;
        logic [2:0]         idx_mode;
        logic [7:0]         data;
        logic [2:0]         last_k;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [23:0]        rgb;
        logic [7:0]         alpha;
        logic               img_last;
    } bpsd_job_t;

    // One pixel on its way to the palette read and the output register.
    typedef struct packed {
        logic               indexed;
        logic [PAL_AW-1:0]  pal_addr;
        logic [23:0]        rgb;
        logic [7:0]         alpha;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               run_last;
        logic               img_last;
    } bpsd_pix_t;

endpackage

`default_nettype wire

// File: hw/rtl/bpsd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bpsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port; a read at the written address returns old data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bpsd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bpsd_front (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_valid,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [bpsd_pkg::DIM_W-1:0] cfg_data,
    input  wire logic                     accept,
    input  wire logic [7:0]               data_byte,
    input  wire logic                     frame_start,
    output bpsd_pkg::bpsd_job_t           job,
    output logic                          job_load,
    output bpsd_pkg::bpsd_pal_wr_t        pal_wr
);

    import bpsd_pkg::*;

    // Configuration registers.
    logic [2:0]       fmt_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    // Parser state.
    logic [PCNT_W-1:0] pal_cnt_reg, pal_cnt_next;
    logic              pal_full_reg, pal_full_next;
    logic [1:0]        phase_reg, phase_next;
    logic [23:0]       partial_reg, partial_next;
    logic [DIM_W-1:0]  col_reg, col_next;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic [1:0]        rbm_reg, rbm_next;
    logic              pad_reg, pad_next;
    logic              done_reg, done_next;

    // State as seen after an optional frame start.
    logic [PCNT_W-1:0] pal_cnt_e;
    logic              pal_full_e;
    logic [1:0]        phase_e;
    logic [23:0]       partial_e;
    logic [DIM_W-1:0]  col_e;
    logic [DIM_W-1:0]  row_e;
    logic [1:0]        rbm_e;
    logic              pad_e;
    logic              done_e;

    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [DIM_W-1:0]  cols_left;
    logic [DIM_W-1:0]  col_step;
    logic [DIM_W-1:0]  row_inc;
    logic [PCNT_W-1:0] pal_top;
    logic [3:0]        npix;
    logic [1:0]        rbm_inc;
    logic              row_end;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg    <= FMT_24BPP;
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FORMAT: fmt_reg    <= cfg_data[2:0];
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the image size to the supported range.
    always_comb begin
        if (width_reg == '0) begin
            w_eff = DIM_W'(1);
        end else if (width_reg > DIM_W'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == '0) begin
            h_eff = DIM_W'(1);
        end else if (height_reg > DIM_W'(MAX_HEIGHT)) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    // Per-byte decode of the stream; all state moves at the beat that brings the byte.
    always_comb begin
        pal_cnt_e  = frame_start ? '0 : pal_cnt_reg;
        pal_full_e = frame_start ? 1'b0 : pal_full_reg;
        phase_e    = frame_start ? 2'd0 : phase_reg;
        partial_e  = frame_start ? 24'd0 : partial_reg;
        col_e      = frame_start ? '0 : col_reg;
        row_e      = frame_start ? '0 : row_reg;
        rbm_e      = frame_start ? 2'd0 : rbm_reg;
        pad_e      = frame_start ? 1'b0 : pad_reg;
        done_e     = (frame_start ? 1'b0 : done_reg) || (row_e >= h_eff);

        pal_cnt_next = pal_cnt_e;
        pal_full_next = pal_full_e;
        phase_next   = phase_e;
        partial_next = partial_e;
        col_next     = col_e;
        row_next     = row_e;
        rbm_next     = rbm_e;
        pad_next     = pad_e;
        done_next    = done_e;

        pal_wr.lane_we = 3'b000;
        pal_wr.addr    = pal_cnt_e[PCNT_W-1:2];
        pal_wr.data    = data_byte;

        cols_left = w_eff - col_e;
        row_inc   = row_e + DIM_W'(1);
        rbm_inc   = rbm_e + 2'd1;
        npix      = 4'd0;
        row_end   = 1'b0;

        job.indexed  = (fmt_reg == FMT_1BPP) || (fmt_reg == FMT_4BPP) ||
                       (fmt_reg == FMT_8BPP);
        job.idx_mode = fmt_reg;
        job.data     = data_byte;
        job.col      = col_e[COORD_W-1:0];
        job.row      = COORD_W'(h_eff - DIM_W'(1) - row_e);
        job.rgb      = {data_byte, partial_e[15:0]};
        job.alpha    = 8'd0;
        job.img_last = 1'b0;

        case (fmt_reg)
            FMT_1BPP: pal_top = PCNT_W'(7);
            FMT_4BPP: pal_top = PCNT_W'(63);
            default:  pal_top = PCNT_W'(1023);
        endcase

        if (done_e || (fmt_reg > FMT_32BPP)) begin
            // Image finished or unknown format: the byte is dropped.
        end else if (job.indexed && !pal_full_e) begin
            // Palette load: B, G and R bytes are stored, the reserved byte is dropped.
            case (pal_cnt_e[1:0])
                LANE_BLUE:  pal_wr.lane_we = 3'b001;
                LANE_GREEN: pal_wr.lane_we = 3'b010;
                LANE_RED:   pal_wr.lane_we = 3'b100;
                default:    pal_wr.lane_we = 3'b000;
            endcase
            if (pal_cnt_e >= pal_top) begin
                pal_full_next = 1'b1;
                pal_cnt_next  = '0;
            end else begin
                pal_cnt_next = pal_cnt_e + PCNT_W'(1);
            end
        end else if (pad_e) begin
            // Row padding up to the four-byte boundary.
            rbm_next = rbm_inc;
            if (rbm_inc == 2'd0) begin
                pad_next = 1'b0;
            end
        end else begin
            case (fmt_reg)
                FMT_1BPP: begin
                    if (col_e < w_eff) begin
                        npix = (cols_left >= DIM_W'(8)) ? 4'd8 : cols_left[3:0];
                    end
                end
                FMT_4BPP: begin
                    if (col_e < w_eff) begin
                        npix = (cols_left >= DIM_W'(2)) ? 4'd2 : 4'd1;
                    end
                end
                FMT_8BPP: begin
                    npix = (col_e < w_eff) ? 4'd1 : 4'd0;
                end
                FMT_24BPP: begin
                    case (phase_e)
                        2'd0: begin
                            partial_next = {16'd0, data_byte};
                            phase_next   = 2'd1;
                        end
                        2'd1: begin
                            partial_next = {8'd0, data_byte, partial_e[7:0]};
                            phase_next   = 2'd2;
                        end
                        default: begin
                            npix       = (col_e < w_eff) ? 4'd1 : 4'd0;
                            phase_next = 2'd0;
                        end
                    endcase
                end
                default: begin
                    job.rgb   = partial_e;
                    job.alpha = data_byte;
                    case (phase_e)
                        2'd0: begin
                            partial_next = {16'd0, data_byte};
                            phase_next   = 2'd1;
                        end
                        2'd1: begin
                            partial_next = {8'd0, data_byte, partial_e[7:0]};
                            phase_next   = 2'd2;
                        end
                        2'd2: begin
                            partial_next = {data_byte, partial_e[15:0]};
                            phase_next   = 2'd3;
                        end
                        default: begin
                            npix       = (col_e < w_eff) ? 4'd1 : 4'd0;
                            phase_next = 2'd0;
                        end
                    endcase
                end
            endcase

            col_step = col_e + DIM_W'(npix);
            col_next = col_step;
            rbm_next = rbm_inc;

            // End of row: wrap the column, count the row, start padding if needed.
            row_end = (job.indexed || (phase_next == 2'd0)) && (col_step >= w_eff);
            if (row_end) begin
                job.img_last = (npix != 4'd0) && (row_inc >= h_eff);
                col_next     = '0;
                phase_next   = 2'd0;
                row_next     = row_inc;
                if (rbm_inc != 2'd0) begin
                    pad_next = 1'b1;
                end
                if (row_inc >= h_eff) begin
                    done_next = 1'b1;
                end
            end
        end

        if (!(done_e || (fmt_reg > FMT_32BPP)) && !(job.indexed && !pal_full_e) && !pad_e) begin
            col_step = col_e + DIM_W'(npix);
        end else begin
            col_step = col_e;
        end

        job.last_k = 3'(npix - 4'd1);
        job_load   = accept && (npix != 4'd0);
        if (!accept) begin
            pal_wr.lane_we = 3'b000;
        end
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pal_cnt_reg  <= '0;
            pal_full_reg <= 1'b0;
            phase_reg    <= 2'd0;
            partial_reg  <= 24'd0;
            col_reg      <= '0;
            row_reg      <= '0;
            rbm_reg      <= 2'd0;
            pad_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end else if (accept) begin
            pal_cnt_reg  <= pal_cnt_next;
            pal_full_reg <= pal_full_next;
            phase_reg    <= phase_next;
            partial_reg  <= partial_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            rbm_reg      <= rbm_next;
            pad_reg      <= pad_next;
            done_reg     <= done_next;
        end
    end

`ifndef SYNTHESIS
    // A finished palette load always leaves the byte count at zero.
    a_pal_full_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        pal_full_reg |-> (pal_cnt_reg == '0))
        else $error("palette count not cleared after load");

    // Padding is only pending while the row is off its four-byte boundary.
    a_pad_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        pad_reg |-> (rbm_reg != 2'd0))
        else $error("padding pending on an aligned row");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/bpsd_expand.sv
`timescale 1ns / 1ps
`default_nettype none

module bpsd_expand (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                job_load,
    input  bpsd_pkg::bpsd_job_t      job_in,
    input  wire logic                adv,
    output logic                     in_ready,
    output logic                     issue_valid,
    output bpsd_pkg::bpsd_pix_t      pix
);

    import bpsd_pkg::*;

    bpsd_job_t  job_reg;
    logic       job_valid_reg, job_valid_next;
    logic [2:0] k_reg, k_next;
    logic       last_pix;

    // One pixel of the held run goes out per advancing cycle.
    always_comb begin
        last_pix     = (k_reg == job_reg.last_k);
        issue_valid  = job_valid_reg && adv;
        in_ready     = !job_valid_reg || (adv && last_pix);

        pix.indexed  = job_reg.indexed;
        pix.rgb      = job_reg.rgb;
        pix.alpha    = job_reg.alpha;
        pix.col      = job_reg.col + COORD_W'(k_reg);
        pix.row      = job_reg.row;
        pix.run_last = last_pix;
        pix.img_last = last_pix && job_reg.img_last;
        case (job_reg.idx_mode)
            FMT_1BPP: pix.pal_addr = {7'd0, job_reg.data[3'd7 - k_reg]};
            FMT_4BPP: pix.pal_addr = (k_reg == 3'd0) ? {4'd0, job_reg.data[7:4]}
                                                     : {4'd0, job_reg.data[3:0]};
            default:  pix.pal_addr = job_reg.data;
        endcase

        job_valid_next = job_valid_reg;
        k_next         = k_reg;
        if (issue_valid) begin
            k_next = k_reg + 3'd1;
            if (last_pix) begin
                job_valid_next = 1'b0;
            end
        end
        if (job_load) begin
            job_valid_next = 1'b1;
            k_next         = 3'd0;
        end
    end

    // Run register and pixel counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            k_reg         <= 3'd0;
        end else begin
            job_valid_reg <= job_valid_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_load) begin
            job_reg <= job_in;
        end
    end

`ifndef SYNTHESIS
    // The pixel counter never runs past the end of the held run.
    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid_reg |-> (k_reg <= job_reg.last_k))
        else $error("pixel counter beyond run length");

    // A new run only lands when the held one has been fully issued.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_load && job_valid_reg) |-> (adv && last_pix))
        else $error("run overwritten before it finished");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/bmp_pixel_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake              Payload
// s_       in         s_valid / s_ready      s_data_byte, s_frame_start
// m_       out        m_valid / m_ready      m_red .. m_alpha, m_column, m_row, flags
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Palette, 8 bpp, 24 bpp and 32 bpp bytes are taken one per cycle while m_ is not stalled.
// A 1 bpp byte occupies the run register for up to eight pixels and a 4 bpp byte for
// up to two: the single palette read port delivers one pixel per cycle while m_ is not stalled.
// A byte's first pixel reaches m_ through the run register, then the output register.
// Reset clears all counters; the palette RAM is not cleared and holds garbage until loaded.
// A stalled m_ side holds the output register and blocks s_ once a run is also waiting.

module bmp_pixel_stream_decoder (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [bpsd_pkg::DIM_W-1:0]   cfg_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [7:0]                   s_data_byte,
    input  wire logic                         s_frame_start,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [7:0]                        m_red,
    output logic [7:0]                        m_green,
    output logic [7:0]                        m_blue,
    output logic [7:0]                        m_alpha,
    output logic [bpsd_pkg::COORD_W-1:0]      m_column,
    output logic [bpsd_pkg::COORD_W-1:0]      m_row,
    output logic                              m_run_last,
    output logic                              m_image_last
);

    import bpsd_pkg::*;

    bpsd_job_t    job;
    bpsd_pal_wr_t pal_wr;
    bpsd_pix_t    pix;
    logic         job_load;
    logic         in_ready;
    logic         issue_valid;
    logic         accept;
    logic         adv;

    logic               m_valid_reg;
    logic               indexed_reg;
    logic [23:0]        rgb_reg;
    logic [7:0]         alpha_reg;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;
    logic               run_last_reg;
    logic               img_last_reg;
    logic [7:0]         pal_r;
    logic [7:0]         pal_g;
    logic [7:0]         pal_b;

    assign cfg_ready = 1'b1;
    assign s_ready   = in_ready;
    assign accept    = s_valid && in_ready;
    assign adv       = !m_valid_reg || m_ready;

    bpsd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .data_byte   (s_data_byte),
        .frame_start (s_frame_start),
        .job         (job),
        .job_load    (job_load),
        .pal_wr      (pal_wr)
    );

    bpsd_expand u_expand (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_load    (job_load),
        .job_in      (job),
        .adv         (adv),
        .in_ready    (in_ready),
        .issue_valid (issue_valid),
        .pix         (pix)
    );

    // Palette storage, one RAM per color lane.
    bpsd_ram #(.WIDTH(8), .DEPTH(PALETTE_DEPTH)) u_pal_b (
        .aclk  (aclk),
        .we    (pal_wr.lane_we[LANE_BLUE]),
        .waddr (pal_wr.addr),
        .wdata (pal_wr.data),
        .re    (adv),
        .raddr (pix.pal_addr),
        .rdata (pal_b)
    );

    bpsd_ram #(.WIDTH(8), .DEPTH(PALETTE_DEPTH)) u_pal_g (
        .aclk  (aclk),
        .we    (pal_wr.lane_we[LANE_GREEN]),
        .waddr (pal_wr.addr),
        .wdata (pal_wr.data),
        .re    (adv),
        .raddr (pix.pal_addr),
        .rdata (pal_g)
    );

    bpsd_ram #(.WIDTH(8), .DEPTH(PALETTE_DEPTH)) u_pal_r (
        .aclk  (aclk),
        .we    (pal_wr.lane_we[LANE_RED]),
        .waddr (pal_wr.addr),
        .wdata (pal_wr.data),
        .re    (adv),
        .raddr (pix.pal_addr),
        .rdata (pal_r)
    );

    // Output register, loaded alongside the palette read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= issue_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            indexed_reg  <= pix.indexed;
            rgb_reg      <= pix.rgb;
            alpha_reg    <= pix.alpha;
            col_reg      <= pix.col;
            row_reg      <= pix.row;
            run_last_reg <= pix.run_last;
            img_last_reg <= pix.img_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_red        = indexed_reg ? pal_r : rgb_reg[23:16];
    assign m_green      = indexed_reg ? pal_g : rgb_reg[15:8];
    assign m_blue       = indexed_reg ? pal_b : rgb_reg[7:0];
    assign m_alpha      = indexed_reg ? 8'd0 : alpha_reg;
    assign m_column     = col_reg;
    assign m_row        = row_reg;
    assign m_run_last   = run_last_reg;
    assign m_image_last = img_last_reg;

`ifndef SYNTHESIS
    // The last pixel of the image always closes its run.
    a_img_last_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && img_last_reg) |-> run_last_reg)
        else $error("image end not on a run end");
`endif

endmodule

`default_nettype wire
